/* src/mbsf_pkg.sv */
package mbsf_pkg;

   // Beat field widths.
   localparam int COEFF_W    = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LOG2_W     = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_A      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_B      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE_T  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOG2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LOG2  = 3'd4;

   // Register reset values.
   localparam logic [15:0]       BLUR_A_RST     = 16'd1638;
   localparam logic [15:0]       BLUR_B_RST     = 16'd1638;
   localparam logic [15:0]       EXPOSURE_T_RST = 16'd4096;
   localparam logic [LOG2_W-1:0] LOG2_RST       = 4'd9;

   // Fixed-point constants, Q.16 radians.
   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int PI_W        = 19;

   // Sine/cosine unit.
   localparam int PHASE_W      = 20;
   localparam int CORDIC_X0    = 39797;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_Q16 [CORDIC_STEPS] = '{
      51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   // Gain path.
   localparam int PROD_W  = 37;
   localparam int QUO_W   = 23;
   localparam int GAIN_W  = QUO_W + 1;
   localparam int HGAIN_W = GAIN_W + PHASE_W - 16;

   localparam logic signed [COEFF_W-1:0] OUT_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
   localparam logic signed [COEFF_W-1:0] OUT_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

endpackage

/* src/motion_blur_spectrum_filter_core.sv */
// Motion-blur transfer function for a centered 2-D spectrum. Each request beat carries
// one coefficient with its row and column; the response beat is the coefficient times
// H = T*sin(theta)/theta*exp(-j*theta), saturated to 40 bits, with a clip flag. The block
// takes one beat per clock while the response is not stalled and returns results in order;
// its depth comes mostly from the 16-stage CORDIC sine/cosine pipeline and the 23-stage
// restoring divider for the sinc gain. A stalled response freezes the whole pipeline; an
// input skid register lets one beat be taken while the output waits. Write the
// configuration registers only while the pipeline is empty.
module motion_blur_spectrum_filter_core #(
   parameter int MAX_DIM_LOG2 = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mbsf_pkg::COEFF_W-1:0]      req_coeff_re,
   input  logic [mbsf_pkg::COEFF_W-1:0]      req_coeff_im,
   input  logic [MAX_DIM_LOG2-1:0]           req_row_index,
   input  logic [MAX_DIM_LOG2-1:0]           req_col_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mbsf_pkg::COEFF_W-1:0]      rsp_out_re,
   output logic [mbsf_pkg::COEFF_W-1:0]      rsp_out_im,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [mbsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbsf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbsf_pkg::*;

   localparam int THETA_W = MAX_DIM_LOG2 + 23;
   localparam int CSIDE_W = 2 * COEFF_W + THETA_W;
   localparam int DSIDE_W = 2 * PHASE_W + 2 + 2 * COEFF_W;

   // Configuration registers.
   logic [15:0]       blur_a_ff, blur_b_ff, exposure_t_ff;
   logic [LOG2_W-1:0] height_log2_ff, width_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blur_a_ff      <= BLUR_A_RST;
         blur_b_ff      <= BLUR_B_RST;
         exposure_t_ff  <= EXPOSURE_T_RST;
         height_log2_ff <= LOG2_RST;
         width_log2_ff  <= LOG2_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BLUR_A:      blur_a_ff      <= csr_wdata[15:0];
            CSR_BLUR_B:      blur_b_ff      <= csr_wdata[15:0];
            CSR_EXPOSURE_T:  exposure_t_ff  <= csr_wdata[15:0];
            CSR_HEIGHT_LOG2: height_log2_ff <= csr_wdata[LOG2_W-1:0];
            CSR_WIDTH_LOG2:  width_log2_ff  <= csr_wdata[LOG2_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance and input skid register.
   logic                    adv;
   logic                    req_take;
   logic                    skid_valid_ff, skid_valid_in;
   logic [COEFF_W-1:0]      skid_re_ff, skid_im_ff;
   logic [MAX_DIM_LOG2-1:0] skid_row_ff, skid_col_ff;
   logic                    src_valid;
   logic [COEFF_W-1:0]      src_re, src_im;
   logic [MAX_DIM_LOG2-1:0] src_row, src_col;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;

   always_comb begin
      src_valid = skid_valid_ff || req_take;
      src_re    = skid_valid_ff ? skid_re_ff  : req_coeff_re;
      src_im    = skid_valid_ff ? skid_im_ff  : req_coeff_im;
      src_row   = skid_valid_ff ? skid_row_ff : req_row_index;
      src_col   = skid_valid_ff ? skid_col_ff : req_col_index;
      if (adv) begin
         skid_valid_in = 1'b0;
      end else begin
         skid_valid_in = skid_valid_ff || req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_take) begin
         skid_re_ff  <= req_coeff_re;
         skid_im_ff  <= req_coeff_im;
         skid_row_ff <= req_row_index;
         skid_col_ff <= req_col_index;
      end
   end

   // Angle and phase.
   logic                      ang_valid;
   logic signed [THETA_W-1:0] ang_theta;
   logic signed [PHASE_W-1:0] ang_phase;
   logic [COEFF_W-1:0]        ang_re, ang_im;

   mbsf_angle #(.MAX_DIM_LOG2(MAX_DIM_LOG2)) u_angle (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (src_valid),
      .row_index   (src_row),
      .col_index   (src_col),
      .coeff_re    (src_re),
      .coeff_im    (src_im),
      .blur_a      (blur_a_ff),
      .blur_b      (blur_b_ff),
      .height_log2 (height_log2_ff),
      .width_log2  (width_log2_ff),
      .out_valid   (ang_valid),
      .theta       (ang_theta),
      .phase       (ang_phase),
      .out_re      (ang_re),
      .out_im      (ang_im)
   );

   // Sine and cosine.
   logic                      cor_valid;
   logic signed [PHASE_W-1:0] cor_cos, cor_sin;
   logic [CSIDE_W-1:0]        cor_side;
   logic [COEFF_W-1:0]        cor_re, cor_im;
   logic signed [THETA_W-1:0] cor_theta;

   mbsf_cordic #(.SIDE_W(CSIDE_W)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ang_valid),
      .phase     (ang_phase),
      .in_side   ({ang_re, ang_im, ang_theta}),
      .out_valid (cor_valid),
      .cos_q     (cor_cos),
      .sin_q     (cor_sin),
      .out_side  (cor_side)
   );

   assign {cor_re, cor_im, cor_theta} = cor_side;

   // Dividend T*sin and the zero-phase test.
   logic                      g1_valid_ff, g2_valid_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      small_ff, small2_ff, neg_ff;
   logic signed [THETA_W-1:0] theta_ff;
   logic signed [PHASE_W-1:0] c1_ff, s1_ff, c2_ff, s2_ff;
   logic [COEFF_W-1:0]        re1_ff, im1_ff, re2_ff, im2_ff;
   logic [PROD_W-1:0]         mag_ff;
   logic [THETA_W-1:0]        den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (adv) begin
         g1_valid_ff <= cor_valid;
         g2_valid_ff <= g1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= $signed({1'b0, exposure_t_ff}) * cor_sin;
         small_ff  <= (cor_theta < THETA_W'(32768)) && (cor_theta > -THETA_W'(32768));
         theta_ff  <= cor_theta;
         c1_ff     <= cor_cos;
         s1_ff     <= cor_sin;
         re1_ff    <= cor_re;
         im1_ff    <= cor_im;
         // Sign-magnitude split for the divider.
         mag_ff    <= prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
         den_ff    <= theta_ff[THETA_W-1] ? THETA_W'(-theta_ff) : THETA_W'(theta_ff);
         neg_ff    <= prod_ff[PROD_W-1] ^ theta_ff[THETA_W-1];
         small2_ff <= small_ff;
         c2_ff     <= c1_ff;
         s2_ff     <= s1_ff;
         re2_ff    <= re1_ff;
         im2_ff    <= im1_ff;
      end
   end

   // Rounded division of the gain.
   logic               div_valid;
   logic [QUO_W-1:0]   div_q;
   logic [DSIDE_W-1:0] div_side;
   logic signed [PHASE_W-1:0] div_cos, div_sin;
   logic               div_small, div_neg;
   logic [COEFF_W-1:0] div_re, div_im;

   mbsf_div #(.DEN_W(THETA_W), .SIDE_W(DSIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (g2_valid_ff),
      .mag       (mag_ff),
      .den       (den_ff),
      .in_side   ({c2_ff, s2_ff, small2_ff, neg_ff, re2_ff, im2_ff}),
      .out_valid (div_valid),
      .quotient  (div_q),
      .out_side  (div_side)
   );

   assign {div_cos, div_sin, div_small, div_neg, div_re, div_im} = div_side;

   // Apply H and saturate.
   mbsf_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (div_valid),
      .quotient   (div_q),
      .zero_phase (div_small),
      .neg        (div_neg),
      .cos_q      (div_cos),
      .sin_q      (div_sin),
      .coeff_re   (div_re),
      .coeff_im   (div_im),
      .exposure_t (exposure_t_ff),
      .out_valid  (rsp_valid),
      .out_re     (rsp_out_re),
      .out_im     (rsp_out_im),
      .saturated  (rsp_saturated)
   );

   // A held beat in the skid register stays until the pipeline moves.
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !adv |=> skid_valid_ff)
      else $error("skid beat lost while stalled");

   // When the pipeline moves, the skid register drains.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && adv |=> !skid_valid_ff)
      else $error("skid beat not drained");

   // A clipped result shows an extreme value in at least one part.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_out_re == OUT_MAX) || (rsp_out_re == OUT_MIN) ||
         (rsp_out_im == OUT_MAX) || (rsp_out_im == OUT_MIN))
      else $error("saturated flag without clipped value");

endmodule

/* src/mbsf_angle.sv */
module mbsf_angle #(
   parameter  int MAX_DIM_LOG2 = 11,
   localparam int THETA_W      = MAX_DIM_LOG2 + 23
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [MAX_DIM_LOG2-1:0]               row_index,
   input  logic [MAX_DIM_LOG2-1:0]               col_index,
   input  logic [mbsf_pkg::COEFF_W-1:0]          coeff_re,
   input  logic [mbsf_pkg::COEFF_W-1:0]          coeff_im,
   input  logic [15:0]                           blur_a,
   input  logic [15:0]                           blur_b,
   input  logic [mbsf_pkg::LOG2_W-1:0]           height_log2,
   input  logic [mbsf_pkg::LOG2_W-1:0]           width_log2,
   output logic                                  out_valid,
   output logic signed [THETA_W-1:0]             theta,
   output logic signed [mbsf_pkg::PHASE_W-1:0]   phase,
   output logic [mbsf_pkg::COEFF_W-1:0]          out_re,
   output logic [mbsf_pkg::COEFF_W-1:0]          out_im
);
   import mbsf_pkg::*;

   localparam int UW   = MAX_DIM_LOG2 + 1;
   localparam int PW   = UW + 16;
   localparam int SW   = PW + 1;
   localparam int MW   = SW + PI_W;
   localparam int PHMW = 15 + PI_W;

   localparam logic signed [PI_W-1:0] PI_S = PI_W'(PI_Q16);

   logic [LOG2_W-1:0]       hl_c, wl_c;
   logic [MAX_DIM_LOG2-1:0] row_m, col_m;
   logic [UW-1:0]           half_h, half_w;
   logic signed [UW-1:0]    u, v;
   logic signed [PW-1:0]    pu_in, pv_in;
   logic signed [PW-1:0]    pu_ff, pv_ff;
   logic signed [SW-1:0]    s_in, s_ff;
   logic signed [14:0]      s_red;
   logic signed [MW-1:0]    mth_in, mth_ff;
   logic signed [PHMW-1:0]  mph_in, mph_ff;
   logic signed [MW-1:0]    th_bias, th_sum;
   logic signed [PHMW-1:0]  ph_bias, ph_sum;
   logic signed [THETA_W-1:0] theta_ff;
   logic signed [PHASE_W-1:0] phase_ff;
   logic [2:0]              valid_ff;
   logic                    valid4_ff;
   logic [COEFF_W-1:0]      re_ff [0:3];
   logic [COEFF_W-1:0]      im_ff [0:3];

   // Clamp the sizes and center the indices.
   always_comb begin
      if (height_log2 == '0) begin
         hl_c = LOG2_W'(1);
      end else if (height_log2 > LOG2_W'(MAX_DIM_LOG2)) begin
         hl_c = LOG2_W'(MAX_DIM_LOG2);
      end else begin
         hl_c = height_log2;
      end
      if (width_log2 == '0) begin
         wl_c = LOG2_W'(1);
      end else if (width_log2 > LOG2_W'(MAX_DIM_LOG2)) begin
         wl_c = LOG2_W'(MAX_DIM_LOG2);
      end else begin
         wl_c = width_log2;
      end
      row_m  = row_index & ~({MAX_DIM_LOG2{1'b1}} << hl_c);
      col_m  = col_index & ~({MAX_DIM_LOG2{1'b1}} << wl_c);
      half_h = UW'(1) << (hl_c - LOG2_W'(1));
      half_w = UW'(1) << (wl_c - LOG2_W'(1));
      u      = $signed({1'b0, row_m}) - $signed(half_h);
      v      = $signed({1'b0, col_m}) - $signed(half_w);
      pu_in  = u * $signed(blur_a);
      pv_in  = v * $signed(blur_b);
   end

   // Sum, then scale by pi for the full angle and the folded phase.
   always_comb begin
      s_in   = pu_ff + pv_ff;
      s_red  = s_ff[14:0];
      mth_in = s_ff * PI_S;
      mph_in = s_red * PI_S;
   end

   // Round both products to Q.16, ties away from zero.
   always_comb begin
      th_bias = mth_ff[MW-1] ? MW'(8191) : MW'(8192);
      ph_bias = mph_ff[PHMW-1] ? PHMW'(8191) : PHMW'(8192);
      th_sum  = mth_ff + th_bias;
      ph_sum  = mph_ff + ph_bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         valid4_ff <= 1'b0;
      end else if (adv) begin
         valid_ff  <= {valid_ff[1:0], in_valid};
         valid4_ff <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pu_ff    <= pu_in;
         pv_ff    <= pv_in;
         s_ff     <= s_in;
         mth_ff   <= mth_in;
         mph_ff   <= mph_in;
         theta_ff <= THETA_W'(th_sum >>> 14);
         phase_ff <= PHASE_W'(ph_sum >>> 14);
         re_ff[0] <= coeff_re;
         im_ff[0] <= coeff_im;
         re_ff[1] <= re_ff[0];
         im_ff[1] <= im_ff[0];
         re_ff[2] <= re_ff[1];
         im_ff[2] <= im_ff[1];
         re_ff[3] <= re_ff[2];
         im_ff[3] <= im_ff[2];
      end
   end

   assign out_valid = valid4_ff;
   assign theta     = theta_ff;
   assign phase     = phase_ff;
   assign out_re    = re_ff[3];
   assign out_im    = im_ff[3];

endmodule

/* src/mbsf_cordic.sv */
module mbsf_cordic #(
   parameter int SIDE_W = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [mbsf_pkg::PHASE_W-1:0] phase,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output logic signed [mbsf_pkg::PHASE_W-1:0] cos_q,
   output logic signed [mbsf_pkg::PHASE_W-1:0] sin_q,
   output logic [SIDE_W-1:0]                   out_side
);
   import mbsf_pkg::*;

   localparam int CW = PHASE_W;
   localparam int NS = CORDIC_STEPS;

   localparam logic signed [CW-1:0] PI_S   = CW'(PI_Q16);
   localparam logic signed [CW-1:0] HALF_S = CW'(HALF_PI_Q16);
   localparam logic signed [CW-1:0] X0_S   = CW'(CORDIC_X0);

   logic signed [CW-1:0] x_ff [0:NS];
   logic signed [CW-1:0] y_ff [0:NS];
   logic signed [CW-1:0] z_ff [0:NS];
   logic                 flip_ff [0:NS];
   logic [SIDE_W-1:0]    side_ff [0:NS];
   logic                 valid_ff [0:NS];
   logic signed [CW-1:0] z0_in;
   logic                 flip_in;
   logic signed [CW-1:0] cos_ff, sin_ff;
   logic [SIDE_W-1:0]    oside_ff;
   logic                 ovalid_ff;

   // Fold the phase into [-pi/2, pi/2]; a fold negates both results.
   always_comb begin
      if (phase > HALF_S) begin
         z0_in   = phase - PI_S;
         flip_in = 1'b1;
      end else if (phase < -HALF_S) begin
         z0_in   = phase + PI_S;
         flip_in = 1'b1;
      end else begin
         z0_in   = phase;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= X0_S;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         flip_ff[0] <= flip_in;
         side_ff[0] <= in_side;
      end
   end

   // One rotation per stage.
   for (genvar i = 0; i < NS; i++) begin : g_iter
      logic signed [CW-1:0] xs, ys;
      logic                 up;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         up = !z_ff[i][CW-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (up) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - CW'(ATAN_Q16[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + CW'(ATAN_Q16[i]);
            end
            flip_ff[i+1] <= flip_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Undo the fold.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (adv) begin
         ovalid_ff <= valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff   <= flip_ff[NS] ? -x_ff[NS] : x_ff[NS];
         sin_ff   <= flip_ff[NS] ? -y_ff[NS] : y_ff[NS];
         oside_ff <= side_ff[NS];
      end
   end

   assign out_valid = ovalid_ff;
   assign cos_q     = cos_ff;
   assign sin_q     = sin_ff;
   assign out_side  = oside_ff;

endmodule

/* src/mbsf_div.sv */
module mbsf_div #(
   parameter int DEN_W  = 34,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [mbsf_pkg::PROD_W-1:0]   mag,
   input  logic [DEN_W-1:0]              den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [mbsf_pkg::QUO_W-1:0]    quotient,
   output logic [SIDE_W-1:0]             out_side
);
   import mbsf_pkg::*;

   localparam int DW = DEN_W + QUO_W + PROD_W + 4;

   logic [DW-1:0]     rem_ff [0:QUO_W];
   logic [DEN_W-1:0]  den_ff [0:QUO_W];
   logic [QUO_W-1:0]  q_ff [0:QUO_W];
   logic [SIDE_W-1:0] side_ff [0:QUO_W];
   logic              valid_ff [0:QUO_W];
   logic [DW-1:0]     num_in;

   // Numerator is the magnitude times 16 plus half the divisor,
   // so truncating division rounds half away from zero.
   assign num_in = (DW'(mag) << 4) + DW'(den >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         side_ff[0] <= in_side;
      end
   end

   // Restoring division, one quotient bit per stage, MSB first.
   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      localparam int SH = QUO_W - 1 - k;
      logic [DW-1:0] trial;
      logic          take;

      always_comb begin
         trial = DW'(den_ff[k]) << SH;
         take  = rem_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= take ? rem_ff[k] - trial : rem_ff[k];
            q_ff[k+1]    <= {q_ff[k][QUO_W-2:0], take};
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quotient  = q_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

/* src/mbsf_mix.sv */
module mbsf_mix (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [mbsf_pkg::QUO_W-1:0]          quotient,
   input  logic                                zero_phase,
   input  logic                                neg,
   input  logic signed [mbsf_pkg::PHASE_W-1:0] cos_q,
   input  logic signed [mbsf_pkg::PHASE_W-1:0] sin_q,
   input  logic [mbsf_pkg::COEFF_W-1:0]        coeff_re,
   input  logic [mbsf_pkg::COEFF_W-1:0]        coeff_im,
   input  logic [15:0]                         exposure_t,
   output logic                                out_valid,
   output logic [mbsf_pkg::COEFF_W-1:0]        out_re,
   output logic [mbsf_pkg::COEFF_W-1:0]        out_im,
   output logic                                saturated
);
   import mbsf_pkg::*;

   localparam int HALF = COEFF_W / 2;
   localparam int GPW  = GAIN_W + PHASE_W;
   localparam int HW   = HGAIN_W;
   localparam int LPW  = HALF + 1 + HW;
   localparam int HPW  = HALF + HW;
   localparam int FW   = COEFF_W + HW;
   localparam int SUMW = FW + 1;
   localparam int RW   = SUMW - 16;

   logic [6:0]              valid_ff;
   logic                    ovalid_ff;
   logic [COEFF_W-1:0]      re_ff [0:2];
   logic [COEFF_W-1:0]      im_ff [0:2];
   logic signed [PHASE_W-1:0] c_ff, s_ff;
   logic signed [GAIN_W-1:0]  g_in, g_ff;
   logic signed [GPW-1:0]     pr_ff, pn_ff;
   logic signed [GPW-1:0]     pr_sum, pn_sum;
   logic signed [HW-1:0]      hr_ff, hn_ff;
   logic signed [HALF:0]      re_lo, im_lo;
   logic signed [HALF-1:0]    re_hi, im_hi;
   logic signed [LPW-1:0]     rl_hr_ff, il_hr_ff, rl_hn_ff, il_hn_ff;
   logic signed [HPW-1:0]     rh_hr_ff, ih_hr_ff, rh_hn_ff, ih_hn_ff;
   logic signed [FW-1:0]      re_hr_ff, im_hr_ff, re_hn_ff, im_hn_ff;
   logic signed [SUMW-1:0]    sre_ff, sim_ff, sre_b, sim_b;
   logic signed [RW-1:0]      rre_ff, rim_ff;
   logic                      re_ok, im_ok;
   logic [COEFF_W-1:0]        ore_ff, oim_ff;
   logic                      sat_ff;

   // Gain: T at zero phase, else the signed rounded quotient.
   always_comb begin
      if (zero_phase) begin
         g_in = GAIN_W'({exposure_t, 4'b0000});
      end else if (neg) begin
         g_in = -$signed({1'b0, quotient});
      end else begin
         g_in = $signed({1'b0, quotient});
      end
   end

   // Round G*cos and G*sin back to Q.16.
   always_comb begin
      pr_sum = pr_ff + (pr_ff[GPW-1] ? GPW'(32767) : GPW'(32768));
      pn_sum = pn_ff + (pn_ff[GPW-1] ? GPW'(32767) : GPW'(32768));
   end

   // Split the coefficients into halves for the partial products.
   always_comb begin
      re_lo = $signed({1'b0, re_ff[2][HALF-1:0]});
      im_lo = $signed({1'b0, im_ff[2][HALF-1:0]});
      re_hi = $signed(re_ff[2][COEFF_W-1:HALF]);
      im_hi = $signed(im_ff[2][COEFF_W-1:HALF]);
   end

   // Final rounding and clip detection.
   always_comb begin
      sre_b = sre_ff + (sre_ff[SUMW-1] ? SUMW'(32767) : SUMW'(32768));
      sim_b = sim_ff + (sim_ff[SUMW-1] ? SUMW'(32767) : SUMW'(32768));
      re_ok = (&rre_ff[RW-1:COEFF_W-1]) || !(|rre_ff[RW-1:COEFF_W-1]);
      im_ok = (&rim_ff[RW-1:COEFF_W-1]) || !(|rim_ff[RW-1:COEFF_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff  <= {valid_ff[5:0], in_valid};
         ovalid_ff <= valid_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Gain select.
         g_ff     <= g_in;
         c_ff     <= cos_q;
         s_ff     <= sin_q;
         re_ff[0] <= coeff_re;
         im_ff[0] <= coeff_im;
         // Gain times cosine and sine.
         pr_ff    <= g_ff * c_ff;
         pn_ff    <= g_ff * s_ff;
         re_ff[1] <= re_ff[0];
         im_ff[1] <= im_ff[0];
         // Real and negated imaginary part of H.
         hr_ff    <= HW'(pr_sum >>> 16);
         hn_ff    <= HW'(pn_sum >>> 16);
         re_ff[2] <= re_ff[1];
         im_ff[2] <= im_ff[1];
         // Partial products.
         rl_hr_ff <= re_lo * hr_ff;
         rh_hr_ff <= re_hi * hr_ff;
         il_hr_ff <= im_lo * hr_ff;
         ih_hr_ff <= im_hi * hr_ff;
         rl_hn_ff <= re_lo * hn_ff;
         rh_hn_ff <= re_hi * hn_ff;
         il_hn_ff <= im_lo * hn_ff;
         ih_hn_ff <= im_hi * hn_ff;
         // Whole products.
         re_hr_ff <= (FW'(rh_hr_ff) <<< HALF) + FW'(rl_hr_ff);
         im_hr_ff <= (FW'(ih_hr_ff) <<< HALF) + FW'(il_hr_ff);
         re_hn_ff <= (FW'(rh_hn_ff) <<< HALF) + FW'(rl_hn_ff);
         im_hn_ff <= (FW'(ih_hn_ff) <<< HALF) + FW'(il_hn_ff);
         // Complex product, with H imaginary = -hn.
         sre_ff   <= SUMW'(re_hr_ff) + SUMW'(im_hn_ff);
         sim_ff   <= SUMW'(im_hr_ff) - SUMW'(re_hn_ff);
         // Round to integer.
         rre_ff   <= RW'(sre_b >>> 16);
         rim_ff   <= RW'(sim_b >>> 16);
         // Saturate into the output register.
         if (re_ok) begin
            ore_ff <= rre_ff[COEFF_W-1:0];
         end else begin
            ore_ff <= rre_ff[RW-1] ? OUT_MIN : OUT_MAX;
         end
         if (im_ok) begin
            oim_ff <= rim_ff[COEFF_W-1:0];
         end else begin
            oim_ff <= rim_ff[RW-1] ? OUT_MIN : OUT_MAX;
         end
         sat_ff <= !re_ok || !im_ok;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_re    = ore_ff;
   assign out_im    = oim_ff;
   assign saturated = sat_ff;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import mbsf_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int DRAIN_CYCLES = 70;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_CYCLES = 400;
   // Register index that the block does not implement.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic signed [COEFF_W-1:0] re;
      logic signed [COEFF_W-1:0] im;
      logic                      sat;
   } filtered_type;

   typedef struct {
      logic [COEFF_W-1:0] re;
      logic [COEFF_W-1:0] im;
      logic [10:0]        row;
      logic [10:0]        col;
      bit                 typed;
      filtered_type       result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COEFF_W-1:0] req_coeff_re = '0;
   logic [COEFF_W-1:0] req_coeff_im = '0;
   logic [10:0] req_row_index = '0;
   logic [10:0] req_col_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COEFF_W-1:0] rsp_out_re;
   logic [COEFF_W-1:0] rsp_out_im;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the filter settings.
   logic [15:0] blur_a_q, blur_b_q, exposure_q;
   logic [3:0] height_q, width_q;

   filtered_type filtered_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_cycles = 0;

   motion_blur_spectrum_filter_core dut (.*);

   always #HALF_PERIOD clock = ~clock;

   function automatic longint round_shift(longint x, int n);
      longint half;
      half = longint'(1) << (n - 1);
      if (x >= 0) return (x + half) >>> n;
      return -((-x + half) >>> n);
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic int clamp_log2(logic [3:0] v);
      if (v < 1) return 1;
      if (v > 11) return 11;
      return int'(v);
   endfunction

   function automatic longint clip40(longint x, ref logic clipped);
      if (x > longint'(OUT_MAX)) begin
         clipped = 1'b1;
         return longint'(OUT_MAX);
      end
      if (x < longint'(OUT_MIN)) begin
         clipped = 1'b1;
         return longint'(OUT_MIN);
      end
      return x;
   endfunction

   // Expected filtered coefficient for one beat under the current settings.
   function automatic filtered_type blur_filter(logic [COEFF_W-1:0] re_in,
                                                logic [COEFF_W-1:0] im_in,
                                                logic [10:0] row_in, logic [10:0] col_in);
      filtered_type r;
      int hl, wl, i;
      longint re, im, u, v, s, s_red, theta, ph, x, y, nx, g, hr, hi;
      logic [14:0] s_low;
      logic flip, clipped;
      hl = clamp_log2(height_q);
      wl = clamp_log2(width_q);
      re = longint'($signed(re_in));
      im = longint'($signed(im_in));
      u = longint'(row_in & ((11'd1 << hl) - 1)) - (longint'(1) << (hl - 1));
      v = longint'(col_in & ((11'd1 << wl) - 1)) - (longint'(1) << (wl - 1));
      s = u * longint'($signed(blur_a_q)) + v * longint'($signed(blur_b_q));
      s_low = s[14:0];
      s_red = longint'($signed(s_low));
      theta = round_shift(s * PI_Q16, 14);
      ph = round_shift(s_red * PI_Q16, 14);
      // Fold the phase into the CORDIC range, then rotate.
      flip = 1'b0;
      if (ph > HALF_PI_Q16) begin
         ph -= PI_Q16;
         flip = 1'b1;
      end else if (ph < -HALF_PI_Q16) begin
         ph += PI_Q16;
         flip = 1'b1;
      end
      x = CORDIC_X0;
      y = 0;
      for (i = 0; i < CORDIC_STEPS; i++) begin
         if (ph >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            ph -= ATAN_Q16[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            ph += ATAN_Q16[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      // Sinc gain, exact at zero phase.
      if (theta < 32768 && theta > -32768) g = longint'(exposure_q) * 16;
      else g = round_div(longint'(exposure_q) * y * 16, theta);
      hr = round_shift(g * x, 16);
      hi = -round_shift(g * y, 16);
      clipped = 1'b0;
      r.re = clip40(round_shift(re * hr - im * hi, 16), clipped);
      r.im = clip40(round_shift(re * hi + im * hr, 16), clipped);
      r.sat = clipped;
      return r;
   endfunction

   // Register write; the enable stays high until cfg_end.
   task automatic cfg_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_BLUR_A: blur_a_q = data;
         CSR_BLUR_B: blur_b_q = data;
         CSR_EXPOSURE_T: exposure_q = data;
         CSR_HEIGHT_LOG2: height_q = data[3:0];
         CSR_WIDTH_LOG2: width_q = data[3:0];
         default: ;
      endcase
   endtask

   task automatic cfg_end();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one beat and return at the edge that accepts it.
   task automatic send_coeff(logic [COEFF_W-1:0] re, logic [COEFF_W-1:0] im,
                             logic [10:0] row, logic [10:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coeff_re <= re;
      req_coeff_im <= im;
      req_row_index <= row;
      req_col_index <= col;
      do @(posedge clock); while (req_stall);
      filtered_q.insert(filtered_q.size(), blur_filter(re, im, row, col));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(3))
         0: return COEFF_W'({$urandom, $urandom});
         1: return COEFF_W'($signed($urandom_range(65535)) - 32768);
         2: return $urandom_range(1) ? OUT_MAX : OUT_MIN;
         default: return COEFF_W'($signed({$urandom, $urandom}) >>> $urandom_range(38));
      endcase
   endfunction

   function automatic logic [15:0] rand_reg16();
      case ($urandom_range(4))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'(int'($urandom_range(4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: random stall, or one long hold-off when it is requested.
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cycles <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      filtered_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected response re=%0d im=%0d", $time,
                     $signed(rsp_out_re), $signed(rsp_out_im));
            errors++;
         end else begin
            e = filtered_q.pop_front();
            if (rsp_out_re !== e.re) begin
               $display("%0t: out_re expected %0d actual %0d", $time, e.re,
                        $signed(rsp_out_re));
               errors++;
            end
            if (rsp_out_im !== e.im) begin
               $display("%0t: out_im expected %0d actual %0d", $time, e.im,
                        $signed(rsp_out_im));
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      stim_row_type dir_rows[$];
      stim_row_type r;
      filtered_type zero_res;
      filtered_type got;
      int p, n;
      blur_a_q = BLUR_A_RST;
      blur_b_q = BLUR_B_RST;
      exposure_q = EXPOSURE_T_RST;
      height_q = LOG2_RST;
      width_q = LOG2_RST;
      zero_res = '{re: '0, im: '0, sat: 1'b0};

      // Directed beats: zero coefficients have a zero result at any setting.
      dir_rows = '{
         '{'0, '0, 11'd256, 11'd256, 1'b1, zero_res},
         '{'0, '0, 11'd0, 11'd0, 1'b1, zero_res},
         '{'0, '0, 11'd2047, 11'd2047, 1'b1, zero_res},
         '{OUT_MAX, OUT_MAX, 11'd256, 11'd256, 1'b0, zero_res},
         '{OUT_MIN, OUT_MIN, 11'd256, 11'd256, 1'b0, zero_res},
         '{OUT_MAX, OUT_MIN, 11'd0, 11'd511, 1'b0, zero_res},
         '{OUT_MIN, OUT_MAX, 11'd511, 11'd0, 1'b0, zero_res},
         '{40'd1, 40'hffffffffff, 11'd257, 11'd256, 1'b0, zero_res},
         '{40'd1000000, 40'd0, 11'd1024, 11'd1800, 1'b0, zero_res},
         '{40'd0, 40'd1000000, 11'd2047, 11'd0, 1'b0, zero_res},
         '{40'h5555555555, 40'haaaaaaaaaa, 11'd300, 11'd200, 1'b0, zero_res},
         '{40'haaaaaaaaaa, 40'h5555555555, 11'd100, 11'd400, 1'b0, zero_res}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset settings, then extreme settings.
      for (p = 0; p < 3; p++) begin
         if (p == 1) begin
            cfg_write(CSR_BLUR_A, 16'h7fff);
            cfg_write(CSR_BLUR_B, 16'h8000);
            cfg_write(CSR_EXPOSURE_T, 16'hffff);
            cfg_write(CSR_HEIGHT_LOG2, 16'd0);
            cfg_write(CSR_WIDTH_LOG2, 16'd15);
            cfg_write(CSR_UNUSED, 16'h1234);
            cfg_end();
         end else if (p == 2) begin
            cfg_write(CSR_BLUR_A, 16'd0);
            cfg_write(CSR_BLUR_B, 16'd0);
            cfg_write(CSR_EXPOSURE_T, 16'hffff);
            cfg_write(CSR_HEIGHT_LOG2, 16'd11);
            cfg_write(CSR_WIDTH_LOG2, 16'd1);
            cfg_end();
         end
         foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_coeff(r.re, r.im, r.row, r.col);
            if (r.typed) begin
               got = filtered_q[$];
               if ((got.re !== r.result.re) || (got.im !== r.result.im) ||
                   (got.sat !== r.result.sat)) begin
                  $display("%0t: row %0d expected %0d/%0d actual prediction %0d/%0d",
                           $time, i, r.result.re, r.result.im, got.re, got.im);
                  errors++;
               end
            end
         end
         drain();
      end

      // Random phases, each with its own settings and idling mode.
      for (p = 0; p < 7; p++) begin
         cfg_write(CSR_BLUR_A, rand_reg16());
         cfg_write(CSR_BLUR_B, rand_reg16());
         cfg_write(CSR_EXPOSURE_T, (p == 6) ? 16'd0 : rand_reg16());
         cfg_write(CSR_HEIGHT_LOG2, {12'($urandom_range(4095)), 4'($urandom_range(15))});
         cfg_write(CSR_WIDTH_LOG2, {12'($urandom_range(4095)), 4'($urandom_range(15))});
         if (p == 5) cfg_write(CSR_UNUSED - 3'($urandom_range(2)), 16'($urandom));
         cfg_end();
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         // Long receiver hold-off so the pipeline fills and stalls the input.
         if (p == 4) begin
            send_idle_pct = 0;
            stall_pct = 0;
            hold_req <= 1'b1;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_coeff(rand_coeff(), rand_coeff(), 11'($urandom), 11'($urandom));
         drain();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
